### sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register map, control word and status types for the PID
// regulator with per-term clamps.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int INTEGRAL_WIDTH = 48;
  localparam int GAIN_W         = 16;
  localparam int STEP_W         = 32;
  localparam int LIMIT_W        = 15;
  localparam int LIM_W          = LIMIT_W + FRAC_BITS;
  localparam int MUL_A_W        = INTEGRAL_WIDTH;
  localparam int PROD_W         = MUL_A_W + GAIN_W;
  localparam int ADDR_W         = 5;
  localparam int PC_W           = 4;
  localparam int DIV_STEPS      = LIM_W;
  localparam int CNT_W          = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_STEP_TIME    = 3'd3,
    REG_OUTPUT_LIMIT = 3'd4,
    REG_P_LIMIT      = 3'd5,
    REG_I_LIMIT      = 3'd6,
    REG_D_LIMIT      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [STEP_W-1:0]  step_time;
    logic [LIMIT_W-1:0] output_limit;
    logic [LIMIT_W-1:0] p_limit;
    logic [LIMIT_W-1:0] i_limit;
    logic [LIMIT_W-1:0] d_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_MUL      = 4'd1,
    OP_INC      = 4'd2,
    OP_INTEG    = 4'd3,
    OP_TERM_P   = 4'd4,
    OP_TERM_I   = 4'd5,
    OP_DIV_INIT = 4'd6,
    OP_DIV_STEP = 4'd7,
    OP_DIV_DONE = 4'd8,
    OP_SUM      = 4'd9,
    OP_OUT      = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    A_MAG_E    = 2'd0,
    A_MAG_INT  = 2'd1,
    A_MAG_DIFF = 2'd2,
    A_DLIM1    = 2'd3
  } a_sel_t;

  typedef enum logic [2:0] {
    B_DT_LO  = 3'd0,
    B_DT_HI  = 3'd1,
    B_GAIN_P = 3'd2,
    B_GAIN_I = 3'd3,
    B_GAIN_D = 3'd4
  } b_sel_t;

  typedef enum logic [2:0] {
    C_NONE         = 3'd0,
    C_PREV_INVALID = 3'd1,
    C_NUM_ZERO     = 3'd2,
    C_OVERFLOW     = 3'd3,
    C_LOOP_MORE    = 3'd4
  } cond_t;

  typedef struct packed {
    op_t             op;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    logic            to_mreg;
    logic            add_hi;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } cw_t;

  typedef struct packed {
    logic prev_invalid;
    logic num_zero;
    logic overflow;
    logic loop_more;
    logic out_busy;
  } status_t;

endpackage

### sv/pidc_regs.sv
// ----------------------------------------------------------------------------
// pidc_regs
// APB register file holding gains, step time and clamp limits.
// ----------------------------------------------------------------------------
module pidc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output pidc_pkg::cfg_t              cfg
);
  import pidc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.step_time    <= STEP_W'(655);
      cfg.output_limit <= '1;
      cfg.p_limit      <= '1;
      cfg.i_limit      <= '1;
      cfg.d_limit      <= '1;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:       cfg.gain_p       <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:       cfg.gain_i       <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:       cfg.gain_d       <= pwdata[GAIN_W-1:0];
        REG_STEP_TIME:    cfg.step_time    <= pwdata[STEP_W-1:0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= pwdata[LIMIT_W-1:0];
        REG_P_LIMIT:      cfg.p_limit      <= pwdata[LIMIT_W-1:0];
        REG_I_LIMIT:      cfg.i_limit      <= pwdata[LIMIT_W-1:0];
        REG_D_LIMIT:      cfg.d_limit      <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:       prdata = 32'(cfg.gain_p);
      REG_GAIN_I:       prdata = 32'(cfg.gain_i);
      REG_GAIN_D:       prdata = 32'(cfg.gain_d);
      REG_STEP_TIME:    prdata = 32'(cfg.step_time);
      REG_OUTPUT_LIMIT: prdata = 32'(cfg.output_limit);
      REG_P_LIMIT:      prdata = 32'(cfg.p_limit);
      REG_I_LIMIT:      prdata = 32'(cfg.i_limit);
      REG_D_LIMIT:      prdata = 32'(cfg.d_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

### sv/pidc_seq.sv
// ----------------------------------------------------------------------------
// pidc_seq
// Microcode sequencer: program ROM, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module pidc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pidc_pkg::status_t status,
  output pidc_pkg::cw_t     cw,
  output logic              in_ready
);
  import pidc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  localparam logic [PC_W-1:0] PC_DIV_LOOP = PC_W'(12);
  localparam logic [PC_W-1:0] PC_SUM      = PC_W'(14);

  state_t          state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  cw_t             rom_cw;
  logic            jump;
  logic            stall;

  function automatic cw_t mk(input op_t op, input a_sel_t a, input b_sel_t b,
                             input logic to_mreg, input logic add_hi,
                             input cond_t cond, input logic [PC_W-1:0] target,
                             input logic last);
    cw_t w;
    w.op      = op;
    w.a_sel   = a;
    w.b_sel   = b;
    w.to_mreg = to_mreg;
    w.add_hi  = add_hi;
    w.cond    = cond;
    w.target  = target;
    w.last    = last;
    return w;
  endfunction

  // program rom
  always_comb begin
    case (pc)
      4'd0:  rom_cw = mk(OP_MUL, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd1:  rom_cw = mk(OP_MUL, A_MAG_E, B_DT_HI, 1'b0, 1'b1, C_NONE, '0, 1'b0);
      4'd2:  rom_cw = mk(OP_INC, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd3:  rom_cw = mk(OP_INTEG, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd4:  rom_cw = mk(OP_MUL, A_MAG_E, B_GAIN_P, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd5:  rom_cw = mk(OP_TERM_P, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd6:  rom_cw = mk(OP_MUL, A_MAG_INT, B_GAIN_I, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd7:  rom_cw = mk(OP_TERM_I, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_PREV_INVALID,
                         PC_SUM, 1'b0);
      4'd8:  rom_cw = mk(OP_MUL, A_MAG_DIFF, B_GAIN_D, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd9:  rom_cw = mk(OP_MUL, A_DLIM1, B_DT_LO, 1'b1, 1'b0, C_NUM_ZERO,
                         PC_SUM, 1'b0);
      4'd10: rom_cw = mk(OP_MUL, A_DLIM1, B_DT_HI, 1'b1, 1'b1, C_NONE, '0, 1'b0);
      4'd11: rom_cw = mk(OP_DIV_INIT, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_OVERFLOW,
                         PC_SUM, 1'b0);
      4'd12: rom_cw = mk(OP_DIV_STEP, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_LOOP_MORE,
                         PC_DIV_LOOP, 1'b0);
      4'd13: rom_cw = mk(OP_DIV_DONE, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd14: rom_cw = mk(OP_SUM, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b0);
      4'd15: rom_cw = mk(OP_OUT, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b1);
      default: rom_cw = mk(OP_NOP, A_MAG_E, B_DT_LO, 1'b0, 1'b0, C_NONE, '0, 1'b1);
    endcase
  end

  always_comb begin
    case (rom_cw.cond)
      C_NONE:         jump = 1'b0;
      C_PREV_INVALID: jump = status.prev_invalid;
      C_NUM_ZERO:     jump = status.num_zero;
      C_OVERFLOW:     jump = status.overflow;
      C_LOOP_MORE:    jump = status.loop_more;
      default:        jump = 1'b0;
    endcase
  end

  // result word waits while the output register is still full
  assign stall    = (state == S_RUN) && (rom_cw.op == OP_OUT) && status.out_busy;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cw = rom_cw;
    if (state != S_RUN || stall) begin
      cw.op = OP_NOP;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          pc_next    = '0;
        end
      end
      S_RUN: begin
        if (!stall) begin
          if (rom_cw.last) begin
            state_next = S_IDLE;
            pc_next    = '0;
          end else if (jump) begin
            pc_next = rom_cw.target;
          end else begin
            pc_next = pc + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        pc_next    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  a_idle_pc: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (pc == '0))
    else $error("step counter not at program start while idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> (state == S_RUN) && (pc == $past(pc)))
    else $error("sequencer moved while result word was blocked");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_RUN) && (pc == '0))
    else $error("sample word did not start the program");

endmodule

### sv/pidc_dp.sv
// ----------------------------------------------------------------------------
// pidc_dp
// Datapath: shared 48x16 multiplier, accumulators, integral, term clamps,
// bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module pidc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  pidc_pkg::cfg_t                  cfg,
  input  pidc_pkg::cw_t                   cw,
  input  logic                            start,
  input  logic                            clear,
  input  logic [pidc_pkg::DATA_WIDTH-1:0] error_value,
  output pidc_pkg::status_t               status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pidc_pkg::DATA_WIDTH-1:0] correction
);
  import pidc_pkg::*;

  localparam int DW        = DATA_WIDTH;
  localparam int IW        = INTEGRAL_WIDTH;
  localparam int DIV_SHIFT = LIM_W - FRAC_BITS;
  localparam int SUM_W     = DW + 2;

  // operand and state registers
  logic [DW-1:0]       e_cur;
  logic [DW-1:0]       mag_e;
  logic                neg_e;
  logic [DW:0]         mag_diff;
  logic                neg_diff;
  logic [IW-1:0]       integral;
  logic [DW-1:0]       prev_err;
  logic                prev_valid;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mreg;
  logic [IW-1:0]       inc;
  logic [DW-1:0]       term_p;
  logic [DW-1:0]       term_i;
  logic [DW-1:0]       term_d;
  logic [DW-1:0]       sum_q;
  logic [STEP_W-1:0]   rem;
  logic [LIM_W-1:0]    nbits;
  logic [LIM_W-1:0]    quo;
  logic [CNT_W-1:0]    cnt;

  // combinational
  logic [DW:0]         diff;
  logic [IW-1:0]       mag_int;
  logic [DW-1:0]       dlim1;
  logic [MUL_A_W-1:0]  mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_hi;
  logic [IW-2:0]       inc_mag;
  logic [IW:0]         integ_sum;
  logic [IW-1:0]       integ_next;
  logic [STEP_W:0]     div_t;
  logic                div_ge;
  logic [STEP_W:0]     div_sub;
  logic [SUM_W-1:0]    sum_raw;
  logic [SUM_W-1:0]    olim;
  logic [DW-1:0]       sum_clamped;
  logic [LIM_W-1:0]    dlim;

  function automatic logic [DW-1:0] sat_term(input logic [PROD_W-1:0] m,
                                             input logic [LIM_W-1:0] lim,
                                             input logic neg);
    logic [LIM_W-1:0] c;
    c = (m > PROD_W'(lim)) ? lim : m[LIM_W-1:0];
    return neg ? (~DW'(c) + 1'b1) : DW'(c);
  endfunction

  assign diff    = {error_value[DW-1], error_value} - {prev_err[DW-1], prev_err};
  assign mag_int = integral[IW-1] ? (~integral + 1'b1) : integral;
  assign dlim    = {cfg.d_limit, {FRAC_BITS{1'b0}}};
  assign dlim1   = DW'(dlim) + 1'b1;

  always_comb begin
    case (cw.a_sel)
      A_MAG_E:    mul_a = MUL_A_W'(mag_e);
      A_MAG_INT:  mul_a = mag_int;
      A_MAG_DIFF: mul_a = MUL_A_W'(mag_diff);
      A_DLIM1:    mul_a = MUL_A_W'(dlim1);
      default:    mul_a = '0;
    endcase
  end

  always_comb begin
    case (cw.b_sel)
      B_DT_LO:  mul_b = cfg.step_time[GAIN_W-1:0];
      B_DT_HI:  mul_b = cfg.step_time[STEP_W-1:GAIN_W];
      B_GAIN_P: mul_b = cfg.gain_p;
      B_GAIN_I: mul_b = cfg.gain_i;
      B_GAIN_D: mul_b = cfg.gain_d;
      default:  mul_b = '0;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_hi = {prod[PROD_W-GAIN_W-1:0], {GAIN_W{1'b0}}};

  // integral increment, magnitude clamped to the positive integral range
  assign inc_mag    = acc[PROD_W-1] ? '1 : acc[PROD_W-2:FRAC_BITS];
  assign integ_sum  = {integral[IW-1], integral} + {inc[IW-1], inc};
  always_comb begin
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_next = integ_sum[IW-1:0];
    end
  end

  // restoring divide step
  assign div_t   = {rem, nbits[LIM_W-1]};
  assign div_ge  = div_t >= {1'b0, cfg.step_time};
  assign div_sub = div_t - {1'b0, cfg.step_time};

  assign sum_raw = {{2{term_p[DW-1]}}, term_p} + {{2{term_i[DW-1]}}, term_i}
                 + {{2{term_d[DW-1]}}, term_d};
  assign olim    = SUM_W'({cfg.output_limit, {FRAC_BITS{1'b0}}});
  always_comb begin
    if ($signed(sum_raw) > $signed(olim)) begin
      sum_clamped = olim[DW-1:0];
    end else if ($signed(sum_raw) < -$signed(olim)) begin
      sum_clamped = (~olim[DW-1:0]) + 1'b1;
    end else begin
      sum_clamped = sum_raw[DW-1:0];
    end
  end

  assign status.prev_invalid = !prev_valid;
  assign status.num_zero     = (acc == '0);
  assign status.overflow     = {acc, {FRAC_BITS{1'b0}}} >= {{FRAC_BITS{1'b0}}, mreg};
  assign status.loop_more    = (cnt != '0);
  assign status.out_busy     = out_valid && !out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      prev_err   <= '0;
      prev_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cw.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (clear) begin
        integral <= '0;
      end
      case (cw.op)
        OP_INTEG: integral <= integ_next;
        OP_OUT: begin
          prev_err   <= e_cur;
          prev_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      e_cur    <= error_value;
      neg_e    <= error_value[DW-1];
      mag_e    <= error_value[DW-1] ? (~error_value + 1'b1) : error_value;
      neg_diff <= diff[DW];
      mag_diff <= diff[DW] ? (~diff + 1'b1) : diff;
      term_d   <= '0;
    end
    case (cw.op)
      OP_MUL: begin
        if (cw.to_mreg) begin
          mreg <= cw.add_hi ? (mreg + prod_hi) : prod;
        end else begin
          acc <= cw.add_hi ? (acc + prod_hi) : prod;
        end
      end
      OP_INC:    inc    <= neg_e ? (~{1'b0, inc_mag} + 1'b1) : {1'b0, inc_mag};
      OP_TERM_P: term_p <= sat_term(acc, {cfg.p_limit, {FRAC_BITS{1'b0}}}, neg_e);
      OP_TERM_I: term_i <= sat_term(acc, {cfg.i_limit, {FRAC_BITS{1'b0}}},
                                    integral[IW-1]);
      OP_DIV_INIT: begin
        if (status.overflow) begin
          term_d <= sat_term(PROD_W'(dlim), dlim, neg_diff);
        end
        rem   <= acc[DIV_SHIFT+STEP_W-1:DIV_SHIFT];
        nbits <= {acc[DIV_SHIFT-1:0], {FRAC_BITS{1'b0}}};
        quo   <= '0;
        cnt   <= CNT_W'(DIV_STEPS - 1);
      end
      OP_DIV_STEP: begin
        rem   <= div_ge ? div_sub[STEP_W-1:0] : div_t[STEP_W-1:0];
        nbits <= {nbits[LIM_W-2:0], 1'b0};
        quo   <= {quo[LIM_W-2:0], div_ge};
        cnt   <= cnt - 1'b1;
      end
      OP_DIV_DONE: term_d <= sat_term(PROD_W'(quo), dlim, neg_diff);
      OP_SUM:      sum_q  <= sum_clamped;
      OP_OUT:      correction <= sum_q;
      default: ;
    endcase
  end

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(correction) <= $signed(olim[DW-1:0]))
              && ($signed(correction) >= -$signed(olim[DW-1:0])))
    else $error("correction word outside output limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIV_STEP) |-> (rem < cfg.step_time))
    else $error("divider remainder not below step time");

  a_integ_only_idle_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> (integral == '0))
    else $error("clear word did not zero the integral");

endmodule

### sv/pid_with_term_clamps.sv
// ----------------------------------------------------------------------------
// pid_with_term_clamps
// Q16.16 PID regulator: saturating integral, clamped P/I/D terms and a
// clamped sum, run by a microcoded sequencer over a shared datapath.
// A sample word without a previous sample skips the derivative term; the zero
// and saturated derivative paths end early, and the rest use the 31-step
// serial divide of the derivative term; a clear word starts no program.
// The next word is taken in the cycle after the program ends, so a sample
// word occupies the input until its program ends, longer while a result waits.
// Reset: registers to defaults, integral zero, no previous sample, no result.
// ----------------------------------------------------------------------------
module pid_with_term_clamps (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] error_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] correction,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pidc_pkg::*;

  cfg_t    cfg;
  cw_t     cw;
  status_t status;
  logic    accept;
  logic    start;
  logic    clear;

  assign accept = in_valid && in_ready;
  assign start  = accept && !kind;
  assign clear  = accept && kind;

  pidc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .status   (status),
    .cw       (cw),
    .in_ready (in_ready)
  );

  pidc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cw          (cw),
    .start       (start),
    .clear       (clear),
    .error_value (error_value),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .correction  (correction)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamped PID regulator. Directed and random
// sample and clear words run under many register settings and flow-control
// patterns; every correction word is compared with a bit-true model.
// ----------------------------------------------------------------------------
module tb;
  import pidc_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 50;
  localparam int REPORT_LIMIT    = 10;

  localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint DATA_MAX  = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint DATA_MIN  = -DATA_MAX - 1;

  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  class correction_tracker;
    cfg_t        cfg;
    longint      integral;
    longint      prior_error;
    bit          last_valid;
    logic [31:0] pending_corrections[$];
    int          failures;
    int          samples;
    int          clears;
    int          checked;

    function new();
      cfg.gain_p       = '0;
      cfg.gain_i       = '0;
      cfg.gain_d       = '0;
      cfg.step_time    = 32'd655;
      cfg.output_limit = 15'd32767;
      cfg.p_limit      = 15'd32767;
      cfg.i_limit      = 15'd32767;
      cfg.d_limit      = 15'd32767;
      integral    = 0;
      prior_error = 0;
      last_valid  = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_GAIN_P:       cfg.gain_p       = v[GAIN_W-1:0];
        REG_GAIN_I:       cfg.gain_i       = v[GAIN_W-1:0];
        REG_GAIN_D:       cfg.gain_d       = v[GAIN_W-1:0];
        REG_STEP_TIME:    cfg.step_time    = v[STEP_W-1:0];
        REG_OUTPUT_LIMIT: cfg.output_limit = v[LIMIT_W-1:0];
        REG_P_LIMIT:      cfg.p_limit      = v[LIMIT_W-1:0];
        REG_I_LIMIT:      cfg.i_limit      = v[LIMIT_W-1:0];
        default:          cfg.d_limit      = v[LIMIT_W-1:0];
      endcase
    endfunction

    function logic [63:0] magnitude(longint v);
      logic [63:0] m;
      m = v;
      if (v < 0) m = -m;
      return m;
    endfunction

    function logic [63:0] limit_units(logic [LIMIT_W-1:0] l);
      logic [63:0] w;
      w = l;
      return w << FRAC_BITS;
    endfunction

    // |a|*b shifted right, capped at lim, sign of a restored
    function longint scale_clamp(longint a, logic [63:0] b, int s, logic [63:0] lim);
      logic [127:0] prod;
      logic [63:0]  m;
      prod = {64'd0, magnitude(a)} * {64'd0, b};
      prod = prod >> s;
      if (prod > {64'd0, lim}) prod = {64'd0, lim};
      m = prod[63:0];
      return (a < 0) ? -$signed(m) : $signed(m);
    endfunction

    function longint derivative_part(longint diff);
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] lim;
      logic [63:0]  m;
      lim = {64'd0, limit_units(cfg.d_limit)};
      num = {64'd0, magnitude(diff)} * {112'd0, cfg.gain_d};
      num = num << FRAC_BITS;
      if (num == 0) return 0;
      if (cfg.step_time == 0) begin
        quo = lim;
      end else begin
        quo = num / {96'd0, cfg.step_time};
        if (quo > lim) quo = lim;
      end
      m = quo[63:0];
      return (diff < 0) ? -$signed(m) : $signed(m);
    endfunction

    function logic [31:0] predict_correction(logic [31:0] word);
      longint e;
      longint inc;
      longint p;
      longint it;
      longint d;
      longint sum;
      longint olim;
      e = $signed(word);
      inc = scale_clamp(e, {32'd0, cfg.step_time}, FRAC_BITS, INTEG_MAX);
      if (inc > 0 && integral > INTEG_MAX - inc) integral = INTEG_MAX;
      else if (inc < 0 && integral < INTEG_MIN - inc) integral = INTEG_MIN;
      else integral += inc;
      p  = scale_clamp(e, {48'd0, cfg.gain_p}, 0, limit_units(cfg.p_limit));
      it = scale_clamp(integral, {48'd0, cfg.gain_i}, 0, limit_units(cfg.i_limit));
      d  = last_valid ? derivative_part(e - prior_error) : 0;
      olim = limit_units(cfg.output_limit);
      sum = p + it + d;
      if (sum > olim) sum = olim;
      if (sum < -olim) sum = -olim;
      if (sum > DATA_MAX) sum = DATA_MAX;
      if (sum < DATA_MIN) sum = DATA_MIN;
      prior_error = e;
      last_valid  = 1;
      return sum[31:0];
    endfunction

    function void note_word(logic k, logic [31:0] w);
      if (k == KIND_CLEAR) begin
        integral = 0;
        clears++;
      end else begin
        samples++;
        pending_corrections.push_back(predict_correction(w));
      end
    endfunction

    function void check_correction(logic [31:0] actual);
      logic [31:0] want;
      if (pending_corrections.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("correction %h with nothing pending", actual);
        return;
      end
      want = pending_corrections.pop_front();
      checked++;
      if (actual !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("correction mismatch: expected %h actual %h", want, actual);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_SAMPLE;
  logic [31:0] error_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] correction;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  correction_tracker tracker;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  pid_with_term_clamps DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .error_value(error_value),
    .out_valid(out_valid), .out_ready(out_ready), .correction(correction),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_correction(correction);
      if (in_valid && in_ready) tracker.note_word(kind, error_value);
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic void set_flow(flow_t f);
    case (f)
      FLOW_FREE:       begin send_idle_pct = 0;  stall_pct = 0;  end
      FLOW_SEND_IDLE:  begin send_idle_pct = 67; stall_pct = 0;  end
      FLOW_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 67; end
      default:         begin send_idle_pct = 8;  stall_pct = 8;  end
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hffff;
      3:       return GAIN_W'($urandom_range(15));
      default: return GAIN_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(6))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'd655;
      3:       return 32'h0001_0000;
      4:       return 32'hffff_ffff;
      5:       return $urandom_range(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 15'd1;
      2:       return 15'd32767;
      3:       return LIMIT_W'($urandom_range(64));
      default: return LIMIT_W'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [31:0] pick_error(logic [31:0] last);
    logic [31:0] v;
    case ($urandom_range(9))
      0:       return last;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3, 4, 5: begin
        v = $urandom_range(524287);
        return v - 32'd262144;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic k, input logic [31:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    error_value <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, v);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_registers(input cfg_t c);
    write_reg(REG_GAIN_P, 32'(c.gain_p));
    write_reg(REG_GAIN_I, 32'(c.gain_i));
    write_reg(REG_GAIN_D, 32'(c.gain_d));
    write_reg(REG_STEP_TIME, c.step_time);
    write_reg(REG_OUTPUT_LIMIT, 32'(c.output_limit));
    write_reg(REG_P_LIMIT, 32'(c.p_limit));
    write_reg(REG_I_LIMIT, 32'(c.i_limit));
    write_reg(REG_D_LIMIT, 32'(c.d_limit));
    apb_release();
  endtask

  // wait for every correction, then let a clear word still in flight finish
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_corrections.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_t        c;
    logic [31:0] last_err;
    int          settings;
    tracker  = new();
    last_err = '0;
    settings = 1;
    set_flow(FLOW_FREE);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gains only: step time and limits stay at reset values
    write_reg(REG_GAIN_P, 32'd3);
    write_reg(REG_GAIN_I, 32'd2);
    write_reg(REG_GAIN_D, 32'd5);
    apb_release();
    // first sample has no derivative
    send_word(KIND_SAMPLE, 32'h7fff_ffff);
    send_word(KIND_SAMPLE, 32'h8000_0000);
    send_word(KIND_SAMPLE, 32'h0000_0000);
    send_word(KIND_SAMPLE, 32'hffff_ffff);
    send_word(KIND_CLEAR, 32'h1234_5678);
    send_word(KIND_SAMPLE, 32'h0001_0000);
    send_word(KIND_CLEAR, 32'h0000_0000);
    send_word(KIND_SAMPLE, 32'h8000_0000);
    drain();

    // zero step time, tight term limits
    c.gain_p = 16'hffff; c.gain_i = 16'hffff; c.gain_d = 16'hffff;
    c.step_time = '0;
    c.output_limit = 15'd32767; c.p_limit = 15'd1; c.i_limit = '0; c.d_limit = 15'd2;
    program_registers(c);
    settings++;
    send_word(KIND_SAMPLE, 32'h0001_0000);
    send_word(KIND_SAMPLE, 32'h0001_0000);
    send_word(KIND_SAMPLE, 32'h0002_0000);
    send_word(KIND_SAMPLE, 32'hfffe_0000);
    send_word(KIND_SAMPLE, 32'h8000_0000);
    send_word(KIND_SAMPLE, 32'h7fff_ffff);
    drain();

    // integral driven into positive saturation, then down toward its negative end
    c.gain_p = '0; c.gain_i = 16'hffff; c.gain_d = 16'd1;
    c.step_time = 32'hffff_ffff;
    c.output_limit = 15'd32767; c.p_limit = 15'd32767;
    c.i_limit = 15'd32767; c.d_limit = 15'd32767;
    program_registers(c);
    settings++;
    send_word(KIND_SAMPLE, 32'h7fff_ffff);
    send_word(KIND_SAMPLE, 32'h7fff_ffff);
    send_word(KIND_SAMPLE, 32'h7fff_ffff);
    send_word(KIND_SAMPLE, 32'h8000_0000);
    send_word(KIND_SAMPLE, 32'h8000_0000);
    send_word(KIND_CLEAR, 32'hffff_ffff);
    drain();

    // smallest non-zero step time, derivative quotient far over its limit
    c.gain_p = '0; c.gain_i = '0; c.gain_d = 16'hffff;
    c.step_time = 32'd1;
    program_registers(c);
    settings++;
    send_word(KIND_SAMPLE, 32'h0000_0000);
    send_word(KIND_SAMPLE, 32'h7fff_ffff);
    send_word(KIND_SAMPLE, 32'h8000_0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) begin
        c.gain_p = 16'hffff; c.gain_i = 16'hffff; c.gain_d = 16'hffff;
        c.step_time = 32'hffff_ffff;
        c.output_limit = 15'd32767; c.p_limit = 15'd32767;
        c.i_limit = 15'd32767; c.d_limit = 15'd32767;
      end else if (ph == 2) begin
        c = '0;
      end else begin
        c.gain_p = pick_gain(); c.gain_i = pick_gain(); c.gain_d = pick_gain();
        c.step_time = pick_step();
        c.output_limit = pick_limit(); c.p_limit = pick_limit();
        c.i_limit = pick_limit(); c.d_limit = pick_limit();
      end
      program_registers(c);
      settings++;
      set_flow(flow_t'(ph % 4));
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(11) == 0) begin
          send_word(KIND_CLEAR, $urandom);
        end else begin
          last_err = pick_error(last_err);
          send_word(KIND_SAMPLE, last_err);
        end
      end
      drain();
    end

    if (tracker.pending_corrections.size() != 0) begin
      tracker.failures += tracker.pending_corrections.size();
      $display("%0d corrections never arrived", tracker.pending_corrections.size());
    end
    $display("covered %0d samples and %0d clears over %0d register settings",
             tracker.samples, tracker.clears, settings);
    $display("%0d corrections checked, %0d failures", tracker.checked, tracker.failures);
    if (tracker.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### pid_with_term_clamps.f
sv/pidc_pkg.sv
sv/pidc_regs.sv
sv/pidc_seq.sv
sv/pidc_dp.sv
sv/pid_with_term_clamps.sv
tb/sv/tb.sv
